@@ rtl/wrs_pkg.sv @@
// ----------------------------------------------------------------------------
// Warp register scoreboard package
// Item and flag types, action codes and slot counts shared by the scoreboard.
// ----------------------------------------------------------------------------
package wrs_pkg;

    localparam int OUT_SLOTS  = 2;
    localparam int IN_SLOTS   = 4;
    localparam int OUT_FIELDS = 2;
    localparam int IN_FIELDS  = 4;

    typedef enum logic [1:0] {
        ACT_RESERVE = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_CHECK   = 2'd2
    } t_action;

    typedef struct packed {
        logic [1:0] action;
        logic [5:0] warp;
        logic       is_long_load;
        logic [7:0] out_reg_0;
        logic [7:0] out_reg_1;
        logic [7:0] in_reg_0;
        logic [7:0] in_reg_1;
        logic [7:0] in_reg_2;
        logic [7:0] in_reg_3;
        logic [7:0] pred_reg;
        logic [7:0] addr_reg_a;
        logic [7:0] addr_reg_b;
    } t_item;

    typedef struct packed {
        logic double_reserve;
        logic warp_pending;
        logic long_hold_hit;
        logic collision;
    } t_flags;

endpackage

@@ rtl/wrs_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module wrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                          i_wr_data,
    input  logic                                      i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/wrs_row_upd.sv @@
// ----------------------------------------------------------------------------
// Scoreboard row update
// Applies one reserve, release or check to a warp row and derives the flags.
// ----------------------------------------------------------------------------
module wrs_row_upd #(
    parameter int NUM_REGS = 256
) (
    input  wrs_pkg::t_item                    i_item,
    input  logic                              i_allow,
    input  logic [NUM_REGS-1:0]               i_pend,
    input  logic [NUM_REGS-1:0]               i_long,
    input  logic [NUM_REGS-1:0]               i_held,
    input  logic [$clog2(NUM_REGS+1)-1:0]     i_pcnt,
    input  logic [$clog2(NUM_REGS+1)-1:0]     i_hcnt,
    output logic [NUM_REGS-1:0]               o_pend,
    output logic [NUM_REGS-1:0]               o_long,
    output logic [NUM_REGS-1:0]               o_held,
    output logic [$clog2(NUM_REGS+1)-1:0]     o_pcnt,
    output logic [$clog2(NUM_REGS+1)-1:0]     o_hcnt,
    output wrs_pkg::t_flags                   o_flags
);

    localparam int RW = $clog2(NUM_REGS);
    localparam int CW = $clog2(NUM_REGS + 1);
    localparam int NPROBE = wrs_pkg::OUT_FIELDS + wrs_pkg::IN_FIELDS + 3;

    function automatic logic [RW-1:0] f_idx(input logic [7:0] r);
        logic [RW-1:0] idx;
        idx = '0;
        if ({1'b0, r} < 9'(NUM_REGS)) begin
            idx = r[RW-1:0];
        end
        return idx;
    endfunction

    logic [RW-1:0] dst [wrs_pkg::OUT_FIELDS];
    logic [RW-1:0] prb [NPROBE];
    logic          hold_empty;

    always_comb begin
        dst[0] = (0 < wrs_pkg::OUT_SLOTS) ? f_idx(i_item.out_reg_0) : '0;
        dst[1] = (1 < wrs_pkg::OUT_SLOTS) ? f_idx(i_item.out_reg_1) : '0;
        prb[0] = dst[0];
        prb[1] = dst[1];
        prb[2] = (0 < wrs_pkg::IN_SLOTS) ? f_idx(i_item.in_reg_0) : '0;
        prb[3] = (1 < wrs_pkg::IN_SLOTS) ? f_idx(i_item.in_reg_1) : '0;
        prb[4] = (2 < wrs_pkg::IN_SLOTS) ? f_idx(i_item.in_reg_2) : '0;
        prb[5] = (3 < wrs_pkg::IN_SLOTS) ? f_idx(i_item.in_reg_3) : '0;
        prb[6] = f_idx(i_item.pred_reg);
        prb[7] = f_idx(i_item.addr_reg_a);
        prb[8] = f_idx(i_item.addr_reg_b);
    end

    always_comb begin
        o_pend     = i_pend;
        o_long     = i_long;
        o_held     = i_held;
        o_pcnt     = i_pcnt;
        o_hcnt     = i_hcnt;
        o_flags    = '0;
        hold_empty = (i_hcnt == '0);
        unique case (wrs_pkg::t_action'(i_item.action))
            wrs_pkg::ACT_RESERVE: begin
                for (int k = 0; k < wrs_pkg::OUT_FIELDS; k++) begin
                    if (dst[k] != '0) begin
                        if (o_pend[dst[k]]) begin
                            if (!i_allow) begin
                                o_flags.double_reserve = 1'b1;
                            end
                        end else begin
                            o_pend[dst[k]] = 1'b1;
                            o_pcnt         = o_pcnt + CW'(1);
                        end
                    end
                end
                if (i_item.is_long_load) begin
                    for (int k = 0; k < wrs_pkg::OUT_FIELDS; k++) begin
                        if (dst[k] != '0) begin
                            o_long[dst[k]] = 1'b1;
                            if (hold_empty && !o_held[dst[k]]) begin
                                o_held[dst[k]] = 1'b1;
                                o_hcnt         = o_hcnt + CW'(1);
                            end
                        end
                    end
                end
            end
            wrs_pkg::ACT_RELEASE: begin
                for (int k = 0; k < wrs_pkg::OUT_FIELDS; k++) begin
                    if (dst[k] != '0) begin
                        if (o_pend[dst[k]]) begin
                            o_pend[dst[k]] = 1'b0;
                            o_pcnt         = o_pcnt - CW'(1);
                        end
                        o_long[dst[k]] = 1'b0;
                        if (o_held[dst[k]]) begin
                            o_held[dst[k]] = 1'b0;
                            o_hcnt         = o_hcnt - CW'(1);
                        end
                    end
                end
            end
            wrs_pkg::ACT_CHECK: begin
                for (int k = 0; k < NPROBE; k++) begin
                    if (prb[k] != '0) begin
                        if (i_pend[prb[k]]) begin
                            o_flags.collision = 1'b1;
                        end
                        if (i_held[prb[k]]) begin
                            o_flags.long_hold_hit = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        o_flags.warp_pending = (o_pcnt != '0);
    end

endmodule

@@ rtl/warp_register_scoreboard.sv @@
// ----------------------------------------------------------------------------
// Warp register scoreboard
// Per-warp pending-write scoreboard for an in-order issue stage.
// ----------------------------------------------------------------------------
// Each input beat names a warp, an action in tuser (reserve, release, check)
// and the long-load flag, with the warp and register slots in tdata. Every
// input beat produces exactly one output beat carrying the collision, held
// long-op hit, warp pending and double reserve flags.
// The whole row of a warp (pending, long-op and held marks plus two counts)
// lives in one RAM word. The row is read when its beat is accepted, then
// updated and written back as the result enters the output register, and
// a new beat can be accepted every cycle while the receiver keeps up.
// A beat for the same warp as the one just written takes the updated row
// from a bypass register instead of the RAM.
// Reset clears a valid flag per warp row; a row not yet written reads as
// all clear, so the block is ready as soon as reset is released.
// When the receiver stalls, the result holds in the output register, one
// more beat waits in the update stage, and then the input side stalls.
// The configuration channel is always ready and should only be written
// while no beat is in flight.
// ----------------------------------------------------------------------------
module warp_register_scoreboard #(
    parameter int NUM_WARPS = 64,
    parameter int NUM_REGS  = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // warp, out_reg_0, out_reg_1, in_reg_0..in_reg_3, pred_reg,
    // addr_reg_a, addr_reg_b, zero fill
    input  logic [79:0] s_axis_tdata,
    // action, is_long_load
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // collision, long_hold_hit, warp_pending, double_reserve, zero fill
    output logic [7:0]  m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);

    localparam int AW    = (NUM_WARPS > 1) ? $clog2(NUM_WARPS) : 1;
    localparam int CW    = $clog2(NUM_REGS + 1);
    localparam int ROW_W = 3 * NUM_REGS + 2 * CW;

    wrs_pkg::t_item  w_in_item;
    wrs_pkg::t_flags w_upd_flags;
    logic            w_acc;
    logic            w_s1_adv;
    logic            w_in_rng;
    logic            w_wr_en;
    logic [AW-1:0]   w_in_addr;
    logic [AW-1:0]   w_s1_addr;
    logic [ROW_W-1:0] w_ram_rdata;
    logic [ROW_W-1:0] w_row_cur;
    logic [ROW_W-1:0] w_row_new;
    logic [NUM_REGS-1:0] w_pend_new;
    logic [NUM_REGS-1:0] w_long_new;
    logic [NUM_REGS-1:0] w_held_new;
    logic [CW-1:0]   w_pcnt_new;
    logic [CW-1:0]   w_hcnt_new;

    logic                 r_allow;
    logic                 r_s1_vld;
    wrs_pkg::t_item       r_s1_item;
    logic                 r_s1_rng;
    logic                 r_fwd_hit;
    logic [ROW_W-1:0]     r_fwd_row;
    logic [NUM_WARPS-1:0] r_row_vld;
    logic                 r_out_vld;
    wrs_pkg::t_flags      r_out_flags;

    always_comb begin
        w_in_item.action       = s_axis_tuser[1:0];
        w_in_item.is_long_load = s_axis_tuser[2];
        w_in_item.warp         = s_axis_tdata[5:0];
        w_in_item.out_reg_0    = s_axis_tdata[13:6];
        w_in_item.out_reg_1    = s_axis_tdata[21:14];
        w_in_item.in_reg_0     = s_axis_tdata[29:22];
        w_in_item.in_reg_1     = s_axis_tdata[37:30];
        w_in_item.in_reg_2     = s_axis_tdata[45:38];
        w_in_item.in_reg_3     = s_axis_tdata[53:46];
        w_in_item.pred_reg     = s_axis_tdata[61:54];
        w_in_item.addr_reg_a   = s_axis_tdata[69:62];
        w_in_item.addr_reg_b   = s_axis_tdata[77:70];
    end

    assign w_s1_adv      = r_s1_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_s1_vld || w_s1_adv;
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_in_rng      = ({1'b0, w_in_item.warp} < 7'(NUM_WARPS));
    assign w_in_addr     = w_in_item.warp[AW-1:0];
    assign w_s1_addr     = r_s1_item.warp[AW-1:0];
    assign w_wr_en       = w_s1_adv && r_s1_rng;

    assign w_row_cur = r_fwd_hit ? r_fwd_row :
                       (r_s1_rng && r_row_vld[w_s1_addr]) ? w_ram_rdata : '0;

    wrs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_WARPS)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_s1_addr),
        .i_wr_data (w_row_new),
        .i_rd_en   (w_acc),
        .i_rd_addr (w_in_addr),
        .o_rd_data (w_ram_rdata)
    );

    wrs_row_upd #(
        .NUM_REGS (NUM_REGS)
    ) u_row_upd (
        .i_item  (r_s1_item),
        .i_allow (r_allow),
        .i_pend  (w_row_cur[NUM_REGS-1:0]),
        .i_long  (w_row_cur[2*NUM_REGS-1:NUM_REGS]),
        .i_held  (w_row_cur[3*NUM_REGS-1:2*NUM_REGS]),
        .i_pcnt  (w_row_cur[3*NUM_REGS+CW-1:3*NUM_REGS]),
        .i_hcnt  (w_row_cur[ROW_W-1:3*NUM_REGS+CW]),
        .o_pend  (w_pend_new),
        .o_long  (w_long_new),
        .o_held  (w_held_new),
        .o_pcnt  (w_pcnt_new),
        .o_hcnt  (w_hcnt_new),
        .o_flags (w_upd_flags)
    );

    assign w_row_new = {w_hcnt_new, w_pcnt_new, w_held_new, w_long_new, w_pend_new};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow   <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_fwd_hit <= 1'b0;
            r_row_vld <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_allow <= i_cfg_data;
            end
            if (w_acc) begin
                r_s1_vld  <= 1'b1;
                r_fwd_hit <= w_wr_en && (w_in_item.warp == r_s1_item.warp);
            end else if (w_s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (w_wr_en) begin
                r_row_vld[w_s1_addr] <= 1'b1;
            end
            if (w_s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_item <= w_in_item;
            r_s1_rng  <= w_in_rng;
            r_fwd_row <= w_row_new;
        end
        if (w_s1_adv) begin
            r_out_flags <= r_s1_rng ? w_upd_flags : '0;
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {4'b0000, r_out_flags};

`ifndef ASSERT_OFF
    a_wr_marks_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |=> r_row_vld[$past(w_s1_addr)])
        else $error("Written row is not marked valid.");

    a_fwd_row_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_fwd_hit) |-> r_row_vld[w_s1_addr])
        else $error("Bypassed row belongs to a warp never written.");

    a_wr_only_on_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_s1_vld && r_s1_rng))
        else $error("Row write without an item in the update stage.");

    a_col_implies_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> m_axis_tdata[2])
        else $error("Collision reported while the warp has no pending write.");

    a_col_dbl_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[3]))
        else $error("Collision and double reserve reported in one beat.");
`endif

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// Warp register scoreboard testbench
// Drives reserve, release and check beats into the scoreboard and compares
// every result beat with flags predicted from a shadow copy of the pending,
// long-op and held marks of all warps, under both re-reserve settings.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 4000;
    localparam int LONG_STALL_CYCLES = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data = 1'b0;

    warp_register_scoreboard dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    bit     pend_mark [64][256];
    bit     long_mark [64][256];
    bit     held_mark [64][256];
    int     pend_cnt [64];
    int     held_cnt [64];
    bit     allow_rereserve = 1'b0;

    wrs_pkg::t_item  item_q [$];
    wrs_pkg::t_item  issued_log [$];
    wrs_pkg::t_flags flags_due [$];
    wrs_pkg::t_item  cur_item;
    logic [5:0] hot_warp [4];
    logic [7:0] hot_reg [8];

    int     src_gap = 0;
    int     sink_gap = 0;
    int     long_stall_left = 0;
    bit     long_stall_done = 1'b0;
    bit     no_idle = 1'b0;
    int     results_seen = 0;
    int     mismatch_count = 0;
    int     idle_cycles = 0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        mismatch_count++;
    endtask

    function automatic void step_scoreboard_row(input wrs_pkg::t_item it);
        wrs_pkg::t_flags f;
        logic [7:0] dst [2];
        logic [7:0] named [9];
        bit         hold_empty;
        int         w;
        f = '0;
        w = int'(it.warp);
        dst = '{it.out_reg_0, it.out_reg_1};
        case (it.action)
            wrs_pkg::ACT_RESERVE: begin
                foreach (dst[k]) begin
                    if (dst[k] != 8'd0) begin
                        if (pend_mark[w][dst[k]]) begin
                            if (!allow_rereserve)
                                f.double_reserve = 1'b1;
                        end else begin
                            pend_mark[w][dst[k]] = 1'b1;
                            pend_cnt[w]++;
                        end
                    end
                end
                if (it.is_long_load) begin
                    hold_empty = (held_cnt[w] == 0);
                    foreach (dst[k]) begin
                        if (dst[k] != 8'd0) begin
                            long_mark[w][dst[k]] = 1'b1;
                            if (hold_empty && !held_mark[w][dst[k]]) begin
                                held_mark[w][dst[k]] = 1'b1;
                                held_cnt[w]++;
                            end
                        end
                    end
                end
            end
            wrs_pkg::ACT_RELEASE: begin
                foreach (dst[k]) begin
                    if (dst[k] != 8'd0) begin
                        if (pend_mark[w][dst[k]]) begin
                            pend_mark[w][dst[k]] = 1'b0;
                            pend_cnt[w]--;
                        end
                        long_mark[w][dst[k]] = 1'b0;
                        if (held_mark[w][dst[k]]) begin
                            held_mark[w][dst[k]] = 1'b0;
                            held_cnt[w]--;
                        end
                    end
                end
            end
            wrs_pkg::ACT_CHECK: begin
                named = '{it.out_reg_0, it.out_reg_1, it.in_reg_0, it.in_reg_1,
                          it.in_reg_2, it.in_reg_3, it.pred_reg, it.addr_reg_a,
                          it.addr_reg_b};
                foreach (named[k]) begin
                    if (named[k] != 8'd0) begin
                        if (pend_mark[w][named[k]])
                            f.collision = 1'b1;
                        if (held_mark[w][named[k]])
                            f.long_hold_hit = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        f.warp_pending = (pend_cnt[w] != 0);
        flags_due.push_back(f);
    endfunction

    function automatic wrs_pkg::t_item mk(input logic [1:0] act, input int w, input int lng,
                                          input int o0, input int o1, input int i0,
                                          input int i1, input int i2, input int i3,
                                          input int p, input int a, input int b);
        wrs_pkg::t_item it;
        it.action = act;
        it.warp = 6'(w);
        it.is_long_load = 1'(lng);
        it.out_reg_0 = 8'(o0);
        it.out_reg_1 = 8'(o1);
        it.in_reg_0 = 8'(i0);
        it.in_reg_1 = 8'(i1);
        it.in_reg_2 = 8'(i2);
        it.in_reg_3 = 8'(i3);
        it.pred_reg = 8'(p);
        it.addr_reg_a = 8'(a);
        it.addr_reg_b = 8'(b);
        return it;
    endfunction

    function automatic logic [7:0] pick_reg();
        int c;
        c = $urandom_range(0, 99);
        if (c < 20)
            return 8'd0;
        if (c < 80)
            return hot_reg[$urandom_range(0, 7)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic wrs_pkg::t_item random_item();
        wrs_pkg::t_item it;
        int    c;
        int    k;
        it.warp = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                              : hot_warp[$urandom_range(0, 3)];
        it.is_long_load = 1'($urandom_range(0, 1));
        it.out_reg_0 = pick_reg();
        it.out_reg_1 = pick_reg();
        it.in_reg_0 = pick_reg();
        it.in_reg_1 = pick_reg();
        it.in_reg_2 = pick_reg();
        it.in_reg_3 = pick_reg();
        it.pred_reg = pick_reg();
        it.addr_reg_a = pick_reg();
        it.addr_reg_b = pick_reg();
        c = $urandom_range(0, 99);
        if (c < 2) begin
            it.action = ACT_UNUSED;
        end else if (c < 36) begin
            it.action = wrs_pkg::ACT_RESERVE;
            issued_log.push_back(it);
        end else if (c < 66) begin
            it.action = wrs_pkg::ACT_RELEASE;
            if (issued_log.size() != 0 && $urandom_range(0, 5) != 0) begin
                k = $urandom_range(0, issued_log.size() - 1);
                it.warp = issued_log[k].warp;
                it.out_reg_0 = issued_log[k].out_reg_0;
                it.out_reg_1 = issued_log[k].out_reg_1;
                issued_log.delete(k);
            end
        end else begin
            it.action = wrs_pkg::ACT_CHECK;
        end
        return it;
    endfunction

    task automatic queue_random(input int n);
        foreach (hot_warp[k])
            hot_warp[k] = 6'($urandom_range(0, 63));
        foreach (hot_reg[k])
            hot_reg[k] = 8'($urandom_range(1, 255));
        repeat (n)
            item_q.push_back(random_item());
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (item_q.size() != 0 || s_axis_tvalid || flags_due.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_allow(input bit v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        allow_rereserve = v;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                step_scoreboard_row(cur_item);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap != 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (item_q.size() != 0) begin
                    cur_item = item_q.pop_front();
                    s_axis_tdata <= {2'b00, cur_item.addr_reg_b, cur_item.addr_reg_a,
                                     cur_item.pred_reg, cur_item.in_reg_3, cur_item.in_reg_2,
                                     cur_item.in_reg_1, cur_item.in_reg_0, cur_item.out_reg_1,
                                     cur_item.out_reg_0, cur_item.warp};
                    s_axis_tuser <= {cur_item.is_long_load, cur_item.action};
                    s_axis_tvalid <= 1'b1;
                    if (!no_idle && $urandom_range(0, 11) == 0)
                        src_gap = $urandom_range(1, 15);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        wrs_pkg::t_flags got;
        wrs_pkg::t_flags want;
        string  names [4];
        names = '{"collision", "long_hold_hit", "warp_pending", "double_reserve"};
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = wrs_pkg::t_flags'(m_axis_tdata[3:0]);
                if (flags_due.size() == 0) begin
                    report_mismatch($sformatf("result beat %0d with no beat outstanding",
                                              results_seen));
                end else begin
                    want = flags_due.pop_front();
                    for (int b = 0; b < 4; b++)
                        if (got[b] !== want[b])
                            report_mismatch($sformatf("result beat %0d %s: got %b, want %b",
                                                      results_seen, names[b], got[b],
                                                      want[b]));
                end
                results_seen++;
            end
            if (long_stall_left != 0) begin
                long_stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!long_stall_done && results_seen >= 900) begin
                long_stall_done = 1'b1;
                long_stall_left = LONG_STALL_CYCLES;
                m_axis_tready <= 1'b0;
            end else if (sink_gap != 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!no_idle && $urandom_range(0, 11) == 0)
                    sink_gap = $urandom_range(1, 15);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_allow(1'b0);

        item_q.push_back(mk(wrs_pkg::ACT_CHECK,    0, 0,   0,   0,   0,   0,   0,   0,
                            0,   0,   0));
        item_q.push_back(mk(wrs_pkg::ACT_RESERVE,  0, 1, 255,   1,   0,   0,   0,   0,
                            0,   0,   0));
        item_q.push_back(mk(wrs_pkg::ACT_CHECK,    0, 0,   0,   0, 255,   0,   0,   0,
                            0,   0,   0));
        item_q.push_back(mk(wrs_pkg::ACT_RESERVE,  0, 1,   0,   5,   0,   0,   0,   0,
                            0,   0,   0));
        item_q.push_back(mk(wrs_pkg::ACT_CHECK,    0, 0,   0,   0,   0,   0,   0,   0,
                            5,   0,   0));
        item_q.push_back(mk(wrs_pkg::ACT_RESERVE,  0, 0, 255,   0,   0,   0,   0,   0,
                            0,   0,   0));
        item_q.push_back(mk(wrs_pkg::ACT_RESERVE, 63, 0,   7,   7,   0,   0,   0,   0,
                            0,   0,   0));
        item_q.push_back(mk(wrs_pkg::ACT_CHECK,   63, 0,   0,   0,   0,   0,   0,   7,
                            0,   0,   0));
        item_q.push_back(mk(wrs_pkg::ACT_RELEASE, 63, 0,   7,   0,   0,   0,   0,   0,
                            0,   0,   0));
        item_q.push_back(mk(wrs_pkg::ACT_RELEASE, 63, 0,   9,   0,   0,   0,   0,   0,
                            0,   0,   0));
        item_q.push_back(mk(ACT_UNUSED,            0, 1, 255, 255, 255, 255, 255, 255,
                            255, 255, 255));
        item_q.push_back(mk(wrs_pkg::ACT_CHECK,    0, 0,   0,   0,   0,   0,   0,   0,
                            0,   0,   1));
        item_q.push_back(mk(wrs_pkg::ACT_CHECK,    0, 0,   0,   0,   0,   0,   2,   0,
                            0,   1,   0));
        item_q.push_back(mk(wrs_pkg::ACT_CHECK,    0, 0,   5,   0,   0,   3,   0,   0,
                            0,   0,   0));
        item_q.push_back(mk(wrs_pkg::ACT_CHECK,    0, 1, 255, 255, 255, 255, 255, 255,
                            255, 255, 255));
        item_q.push_back(mk(wrs_pkg::ACT_RELEASE,  0, 1, 255,   1,   0,   0,   0,   0,
                            0,   0,   0));
        item_q.push_back(mk(wrs_pkg::ACT_CHECK,    0, 0,   0,   5,   0,   0,   0,   0,
                            0,   0,   0));
        item_q.push_back(mk(wrs_pkg::ACT_RELEASE,  0, 0,   5,   0,   0,   0,   0,   0,
                            0,   0,   0));
        item_q.push_back(mk(wrs_pkg::ACT_CHECK,    0, 0, 255,   1,   5,   0,   0,   0,
                            0,   0,   0));
        item_q.push_back(mk(wrs_pkg::ACT_RESERVE,  0, 1,   5,   0,   0,   0,   0,   0,
                            0,   0,   0));
        item_q.push_back(mk(wrs_pkg::ACT_RELEASE,  0, 0,   0,   5,   0,   0,   0,   0,
                            0,   0,   0));
        wait_drained();

        write_allow(1'b1);
        item_q.push_back(mk(wrs_pkg::ACT_RESERVE,  1, 0,   3,   0,   0,   0,   0,   0,
                            0,   0,   0));
        item_q.push_back(mk(wrs_pkg::ACT_RESERVE,  1, 1,   3,   3,   0,   0,   0,   0,
                            0,   0,   0));
        queue_random(600);
        wait_drained();

        write_allow(1'b0);
        queue_random(600);
        wait_drained();

        write_allow(1'b1);
        queue_random(300);
        wait_drained();

        no_idle = 1'b1;
        write_allow(1'b0);
        queue_random(300);
        wait_drained();

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/wrs_pkg.sv
rtl/wrs_ram.sv
rtl/wrs_row_upd.sv
rtl/warp_register_scoreboard.sv
sim/tb_top.sv
